/* hdl/alm_pkg.sv */
// ----------------------------------------------------------------------------
// alm_pkg
// Shared types and constants for the array list engine: widths, command
// and status codes, and the control and chain structs of the cell row.
// ----------------------------------------------------------------------------
package alm_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMD_W    = 3;
	localparam int POS_W    = 5;
	localparam int DATA_W   = 8;
	localparam int STAT_W   = 3;
	localparam int FIDX_W   = 4;
	localparam int LEN_W    = 5;

	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_MODIFY = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

	localparam logic [DATA_W-1:0] SPACE_CHAR = 8'd32;

	// broadcast to every cell for one command
	typedef struct packed {
		logic              wr;
		logic [IDX_W-1:0]  wr_idx;
		logic              shift;
		logic [POS_W-1:0]  rm_pos;
		logic [POS_W-1:0]  rd_pos;
		logic [DATA_W-1:0] value;
		logic [CNT_W-1:0]  count;
	} cell_ctrl_t;

	// rippled from cell to cell: search hit, read data, first-hit index
	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] rd;
		logic [IDX_W-1:0]  fidx;
	} cell_chain_t;

endpackage

/* hdl/alm_cell.sv */
// ----------------------------------------------------------------------------
// alm_cell
// One list slot: holds one element, takes a write or its upper neighbor's
// element on a remove, and extends the search and read chains.
// ----------------------------------------------------------------------------
module alm_cell (
	input  logic                        clk,
	input  alm_pkg::cell_ctrl_t         ctrl,
	input  logic [alm_pkg::IDX_W-1:0]   idx,
	input  logic [alm_pkg::DATA_W-1:0]  next_data,
	input  alm_pkg::cell_chain_t        chain_in,
	output logic [alm_pkg::DATA_W-1:0]  data,
	output alm_pkg::cell_chain_t        chain_out
);
	import alm_pkg::*;

	logic [DATA_W-1:0] data_q;
	logic [CNT_W-1:0]  idx_c;
	logic [POS_W-1:0]  idx_p;
	logic              live;
	logic              match;
	logic              first;
	logic              do_wr;
	logic              do_shift;

	assign idx_c = CNT_W'(idx);
	assign idx_p = POS_W'(idx);
	assign live  = idx_c < ctrl.count;
	assign match = live && (data_q == ctrl.value);
	assign first = match && !chain_in.hit;

	assign do_wr    = ctrl.wr && (idx == ctrl.wr_idx);
	assign do_shift = ctrl.shift && (idx_p >= ctrl.rm_pos) && ((idx_c + 1'b1) < ctrl.count);

	always_ff @(posedge clk) begin
		if (do_wr) begin
			data_q <= ctrl.value;
		end else if (do_shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

	always_comb begin
		chain_out.hit  = chain_in.hit | match;
		chain_out.rd   = chain_in.rd | ((idx_p == ctrl.rd_pos) ? data_q : '0);
		chain_out.fidx = chain_in.fidx | (first ? idx : '0);
	end

endmodule

/* hdl/array_list_engine_top.sv */
// ----------------------------------------------------------------------------
// array_list_engine_top
// Byte array list with append, modify, remove, read and search commands.
// ----------------------------------------------------------------------------
// One command item is taken in every clock cycle; busy is never raised.
// Its result appears on the result ports, marked by done, in the cycle after
// the item is accepted and for that cycle only, so the receiver must take it
// then. The list lives in a row of one-element cells that all update in the
// accepting cycle: a remove shifts every later cell down by one in that edge,
// and search and read ripple through the row, which sets the cycle time.
module array_list_engine_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [alm_pkg::CMD_W-1:0]   cmd,
	input  logic [alm_pkg::POS_W-1:0]   position,
	input  logic [alm_pkg::DATA_W-1:0]  value,
	output logic                        done,
	output logic                        ok,
	output logic [alm_pkg::STAT_W-1:0]  status,
	output logic [alm_pkg::DATA_W-1:0]  read_value,
	output logic [alm_pkg::FIDX_W-1:0]  found_index,
	output logic [alm_pkg::LEN_W-1:0]   length
);
	import alm_pkg::*;

	logic              accept;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic              empty;
	logic              full;
	logic              pos_valid;
	cell_ctrl_t        ctrl;
	cell_chain_t       chain [CAPACITY+1];
	logic [DATA_W-1:0] cell_data [CAPACITY];

	logic              ok_d;
	logic [STAT_W-1:0] status_d;
	logic [DATA_W-1:0] rd_d;
	logic [FIDX_W-1:0] fidx_d;

	logic              done_q;
	logic              ok_q;
	logic [STAT_W-1:0] status_q;
	logic [DATA_W-1:0] rd_q;
	logic [FIDX_W-1:0] fidx_q;
	logic [LEN_W-1:0]  len_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign pos_valid = (CNT_W'(position) < count_q) && (position < POS_W'(CAPACITY));

	always_comb begin
		ctrl.wr     = 1'b0;
		ctrl.wr_idx = position[IDX_W-1:0];
		ctrl.shift  = 1'b0;
		ctrl.rm_pos = position;
		ctrl.rd_pos = position;
		ctrl.value  = value;
		ctrl.count  = count_q;
		count_d     = count_q;
		ok_d        = 1'b0;
		status_d    = ST_OK;
		rd_d        = '0;
		fidx_d      = '0;
		case (cmd)
			CMD_APPEND: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.wr     = accept;
					ctrl.wr_idx = count_q[IDX_W-1:0];
					count_d     = count_q + 1'b1;
					ok_d        = 1'b1;
				end
			end
			CMD_MODIFY, CMD_REMOVE, CMD_READ: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (!pos_valid) begin
					status_d = ST_BADPOS;
				end else begin
					ok_d = 1'b1;
					if (cmd == CMD_MODIFY) begin
						ctrl.wr = accept;
					end else if (cmd == CMD_REMOVE) begin
						ctrl.shift = accept;
						count_d    = count_q - 1'b1;
					end else begin
						rd_d = chain[CAPACITY].rd;
					end
				end
				if (cmd == CMD_READ && !ok_d) begin
					rd_d = SPACE_CHAR;
				end
			end
			CMD_SEARCH: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (chain[CAPACITY].hit) begin
					ok_d   = 1'b1;
					fidx_d = FIDX_W'(chain[CAPACITY].fidx);
				end else begin
					status_d = ST_NOTFOUND;
				end
			end
			default: begin
				status_d = ST_BADPOS;
			end
		endcase
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] nxt;
		if (i == CAPACITY - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end
		alm_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.idx       (IDX_W'(i)),
			.next_data (nxt),
			.chain_in  (chain[i]),
			.data      (cell_data[i]),
			.chain_out (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q     <= ok_d;
			status_q <= status_d;
			rd_q     <= rd_d;
			fidx_q   <= fidx_d;
			len_q    <= LEN_W'(count_d);
		end
	end

	assign done        = done_q;
	assign ok          = ok_q;
	assign status      = status_q;
	assign read_value  = rd_q;
	assign found_index = fidx_q;
	assign length      = len_q;

endmodule
